// File: design/command_ack_tracker_assert.svh
// Assertion macros used by the core design file of the acknowledgement tracker.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef COMMAND_ACK_TRACKER_ASSERT_SVH
`define COMMAND_ACK_TRACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMDACK_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CMDACK_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The expression must hold at every clock edge out of reset.
`define CMDACK_ASSERT_ALW(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

// File: design/cmdack_pkg.sv
`default_nettype none

package cmdack_pkg;

    // Largest number of commands in one batch.
    localparam int MAX_COMMANDS = 64;
    // Width of the elapsed tick counter; it saturates at its top value.
    localparam int TICK_BITS = 16;
    // Width of the quiet window end point (elapsed plus quiet ticks).
    localparam int QEND_W = TICK_BITS + 1;

    localparam int ACK_W  = 7;
    localparam int DL_W   = 16;
    localparam int QT_W   = 16;
    localparam int CAP_W  = 13;
    localparam int DATA_W = 16;

    localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_PLUS = 8'h2B;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_TICK  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CFG_EXPECTED = 2'd0,
        CFG_DEADLINE = 2'd1,
        CFG_QUIET    = 2'd2,
        CFG_MAX_BYTES = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        OUT_PENDING    = 2'd0,
        OUT_SUCCESS    = 2'd1,
        OUT_UNRESOLVED = 2'd2,
        OUT_FAILURE    = 2'd3
    } outcome_t;

    typedef enum logic [3:0] {
        RSN_NONE       = 4'd0,
        RSN_EMPTY      = 4'd1,
        RSN_BOUNDS     = 4'd2,
        RSN_BYTE_CAP   = 4'd3,
        RSN_BAD_LINE   = 4'd4,
        RSN_EXTRA_ACK  = 4'd5,
        RSN_QUIET_LATE = 4'd6,
        RSN_PARTIAL    = 4'd7,
        RSN_ACK_TMO    = 4'd8,
        RSN_QUIET_TMO  = 4'd9
    } reason_t;

    // Line assembly state, one-hot.
    typedef enum logic [2:0] {
        LINE_EMPTY = 3'b001,
        LINE_PLUS  = 3'b010,
        LINE_OTHER = 3'b100
    } line_t;

    typedef struct packed {
        logic [ACK_W-1:0] expected_acks;
        logic [DL_W-1:0]  ack_deadline_ticks;
        logic [QT_W-1:0]  quiet_ticks;
        logic [CAP_W-1:0] max_reply_bytes;
    } cfg_t;

    typedef struct packed {
        logic             done;
        outcome_t         outcome;
        reason_t          reason;
        logic [ACK_W-1:0] acks;
    } result_t;

endpackage

`default_nettype wire

// File: design/cmdack_cfg.sv
`default_nettype none

module cmdack_cfg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [cmdack_pkg::DATA_W-1:0] cfg_data,
    output cmdack_pkg::cfg_t                cfg
);
    import cmdack_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_EXPECTED:  cfg_next.expected_acks      = cfg_data[ACK_W-1:0];
                CFG_DEADLINE:  cfg_next.ack_deadline_ticks = cfg_data[DL_W-1:0];
                CFG_QUIET:     cfg_next.quiet_ticks        = cfg_data[QT_W-1:0];
                CFG_MAX_BYTES: cfg_next.max_reply_bytes    = cfg_data[CAP_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_acks      <= ACK_W'(1);
            cfg_reg.ack_deadline_ticks <= DL_W'(100);
            cfg_reg.quiet_ticks        <= QT_W'(10);
            cfg_reg.max_reply_bytes    <= CAP_W'(256);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: design/cmdack_core.sv
`default_nettype none

module cmdack_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  fire,
    input  wire logic [1:0]            kind,
    input  wire logic [7:0]            rx_byte,
    input  wire cmdack_pkg::cfg_t      cfg,
    output cmdack_pkg::result_t        res
);
    import cmdack_pkg::*;

    `include "command_ack_tracker_assert.svh"

    logic                 active_reg,  active_next;
    logic [ACK_W-1:0]     ack_reg,     ack_next;
    logic [CAP_W-1:0]     bytes_reg,   bytes_next;
    line_t                line_reg,    line_next;
    logic [TICK_BITS-1:0] elapsed_reg, elapsed_next;
    logic                 armed_reg,   armed_next;
    logic [QEND_W-1:0]    qend_reg,    qend_next;

    // One bit wider than the count so that an extra ack past the largest
    // expected value is still seen as extra.
    logic [ACK_W:0]       ack_inc;
    logic [ACK_W:0]       expected_ext;
    logic [TICK_BITS-1:0] elapsed_inc;
    logic [QEND_W-1:0]    qend_calc;
    logic [QEND_W-1:0]    deadline_ext;
    logic                 is_eol;

    assign ack_inc      = {1'b0, ack_reg} + (ACK_W+1)'(1);
    assign expected_ext = {1'b0, cfg.expected_acks};
    assign elapsed_inc  = (elapsed_reg == TICK_MAX) ? elapsed_reg
                                                    : elapsed_reg + TICK_BITS'(1);
    assign qend_calc    = QEND_W'(elapsed_reg) + QEND_W'(cfg.quiet_ticks);
    assign deadline_ext = QEND_W'(cfg.ack_deadline_ticks);
    assign is_eol       = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);

    always_comb
    begin
        active_next  = active_reg;
        ack_next     = ack_reg;
        bytes_next   = bytes_reg;
        line_next    = line_reg;
        elapsed_next = elapsed_reg;
        armed_next   = armed_reg;
        qend_next    = qend_reg;

        res.done    = 1'b0;
        res.outcome = OUT_PENDING;
        res.reason  = RSN_NONE;
        res.acks    = ack_reg;

        if (fire)
        begin
            case (kind_t'(kind))
                KIND_START:
                begin
                    // A new start drops whatever was running.
                    active_next  = 1'b0;
                    ack_next     = '0;
                    bytes_next   = '0;
                    line_next    = LINE_EMPTY;
                    elapsed_next = '0;
                    armed_next   = 1'b0;
                    qend_next    = '0;
                    res.acks     = '0;
                    if (cfg.expected_acks == '0)
                    begin
                        res.done    = 1'b1;
                        res.outcome = OUT_FAILURE;
                        res.reason  = RSN_EMPTY;
                    end
                    else if (32'(cfg.expected_acks) > MAX_COMMANDS
                             || cfg.ack_deadline_ticks == '0
                             || cfg.max_reply_bytes == '0)
                    begin
                        res.done    = 1'b1;
                        res.outcome = OUT_FAILURE;
                        res.reason  = RSN_BOUNDS;
                    end
                    else
                    begin
                        active_next = 1'b1;
                    end
                end
                KIND_BYTE:
                begin
                    if (active_reg)
                    begin
                        if (bytes_reg >= cfg.max_reply_bytes)
                        begin
                            res.done    = 1'b1;
                            res.outcome = OUT_UNRESOLVED;
                            res.reason  = RSN_BYTE_CAP;
                        end
                        else
                        begin
                            bytes_next = bytes_reg + CAP_W'(1);
                            if (!is_eol)
                            begin
                                line_next = (line_reg == LINE_EMPTY && rx_byte == CHAR_PLUS)
                                            ? LINE_PLUS : LINE_OTHER;
                            end
                            else if (line_reg != LINE_PLUS)
                            begin
                                res.done    = 1'b1;
                                res.outcome = OUT_UNRESOLVED;
                                res.reason  = RSN_BAD_LINE;
                            end
                            else
                            begin
                                line_next = LINE_EMPTY;
                                ack_next  = ack_inc[ACK_W-1:0];
                                res.acks  = ack_inc[ACK_W-1:0];
                                if (ack_inc > expected_ext)
                                begin
                                    res.done    = 1'b1;
                                    res.outcome = OUT_UNRESOLVED;
                                    res.reason  = RSN_EXTRA_ACK;
                                end
                                else if (ack_inc == expected_ext)
                                begin
                                    qend_next = qend_calc;
                                    if (qend_calc > deadline_ext)
                                    begin
                                        res.done    = 1'b1;
                                        res.outcome = OUT_UNRESOLVED;
                                        res.reason  = RSN_QUIET_LATE;
                                    end
                                    else
                                    begin
                                        armed_next = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                KIND_TICK:
                begin
                    if (active_reg)
                    begin
                        elapsed_next = elapsed_inc;
                        if (QEND_W'(elapsed_inc) >= deadline_ext)
                        begin
                            res.done    = 1'b1;
                            res.outcome = OUT_UNRESOLVED;
                            if (line_reg != LINE_EMPTY)
                            begin
                                res.reason = RSN_PARTIAL;
                            end
                            else if (ack_reg != cfg.expected_acks)
                            begin
                                res.reason = RSN_ACK_TMO;
                            end
                            else
                            begin
                                res.reason = RSN_QUIET_TMO;
                            end
                        end
                        else if (armed_reg && ack_reg == cfg.expected_acks
                                 && QEND_W'(elapsed_inc) >= qend_reg)
                        begin
                            res.done    = 1'b1;
                            res.outcome = OUT_SUCCESS;
                        end
                    end
                end
                default:
                begin
                    active_next = active_reg;
                end
            endcase
            if (res.done)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            ack_reg     <= '0;
            bytes_reg   <= '0;
            line_reg    <= LINE_EMPTY;
            elapsed_reg <= '0;
            armed_reg   <= 1'b0;
            qend_reg    <= '0;
        end
        else
        begin
            active_reg  <= active_next;
            ack_reg     <= ack_next;
            bytes_reg   <= bytes_next;
            line_reg    <= line_next;
            elapsed_reg <= elapsed_next;
            armed_reg   <= armed_next;
            qend_reg    <= qend_next;
        end
    end

    // A finished transaction always carries a final outcome.
    `CMDACK_ASSERT_IMP(a_done_has_outcome, res.done, res.outcome != OUT_PENDING,
        "done without outcome")
    // Items that end nothing report pending with no reason.
    `CMDACK_ASSERT_IMP(a_pending_clean, !res.done,
        res.outcome == OUT_PENDING && res.reason == RSN_NONE,
        "pending result carries a reason")
    // At most one acknowledgement beyond the largest batch is ever counted.
    `CMDACK_ASSERT_ALW(a_ack_bound, 32'(ack_reg) <= MAX_COMMANDS + 1,
        "ack count out of range")
    // A start always clears the acknowledgement count and the byte count.
    `CMDACK_ASSERT_NXT(a_start_clears, fire && kind == KIND_START,
        ack_reg == '0 && bytes_reg == '0, "start did not clear counters")

endmodule

`default_nettype wire

// File: design/command_ack_tracker.sv
// Channel   Direction  Handshake             Payload
// in        request    in_valid / in_stall   kind, rx_byte
// out       result     out_valid / out_stall done_res, outcome, reason, acks_seen
// cfg       write      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Every request produces exactly one result via the input and result registers.
// A new request can be taken every cycle while in_stall is low; the tracker
// state is updated by the core as a request moves from the input register to the
// result register. rst_n clears the configuration to its defaults and the tracker
// to idle. A stalled result holds in the result register while one more request
// waits in the input register; in_stall rises only when both are full.
`default_nettype none

module command_ack_tracker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    kind,
    input  wire logic [7:0]                    rx_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               done_res,
    output logic [1:0]                         outcome,
    output logic [3:0]                         reason,
    output logic [6:0]                         acks_seen,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [cmdack_pkg::DATA_W-1:0] cfg_data
);
    import cmdack_pkg::*;

    cfg_t    cfg;
    result_t res;

    // Input register holding one request.
    logic       s1_valid_reg, s1_valid_next;
    logic [1:0] kind_reg;
    logic [7:0] byte_reg;

    // Result register.
    logic    out_valid_reg, out_valid_next;
    result_t res_reg;

    logic in_take;
    logic fire;

    // The held request moves on when the result register is free or being drained.
    assign fire     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !fire;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next  = in_take || (s1_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && out_stall);

    cmdack_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cmdack_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .kind    (kind_reg),
        .rx_byte (byte_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg <= kind;
            byte_reg <= rx_byte;
        end
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign done_res  = res_reg.done;
    assign outcome   = res_reg.outcome;
    assign reason    = res_reg.reason;
    assign acks_seen = res_reg.acks;

endmodule

`default_nettype wire

// File: verif/command_ack_tracker_test.sv
`timescale 1ns / 100ps

module command_ack_tracker_test;

    import cmdack_pkg::*;

    // The package names only three request kinds. The fourth code carries no
    // meaning, and the tracker must answer it with a pending result.
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    // Cycles without any handshake before the run is declared hung.
    localparam int HANG_LIMIT = 5000;

    // Enough requests to move the tracker through every outcome many times.
    localparam int REQUEST_GOAL = 2000;

    // Longest run of ticks sent to close one exchange. After it, line ends
    // are sent until the tracker gives up, so no exchange stays open forever.
    localparam int TICK_BUDGET = 300;

    // The scoreboard keeps its own copy of the tracker's settings and state.
    // For every accepted request it works out the result that the tracker must
    // give and queues it. Each result that comes out is compared with the
    // oldest queued one.
    class ack_outcome_board;
        logic [ACK_W-1:0]     want_acks;
        logic [DL_W-1:0]      deadline;
        logic [QT_W-1:0]      quiet_len;
        logic [CAP_W-1:0]     byte_cap;

        bit                   busy;
        logic [ACK_W-1:0]     acks;
        logic [CAP_W-1:0]     rx_count;
        line_t                line;
        logic [TICK_BITS-1:0] elapsed;
        bit                   armed;
        logic [QEND_W-1:0]    quiet_end;

        result_t              awaited[$];
        int                   errors;
        int                   requests;
        int                   counted;
        int                   checked;
        int                   outcomes[4];

        function new();
            want_acks = ACK_W'(1);
            deadline  = DL_W'(100);
            quiet_len = QT_W'(10);
            byte_cap  = CAP_W'(256);
            clear_session();
        endfunction

        function void clear_session();
            busy      = 1'b0;
            acks      = '0;
            rx_count  = '0;
            line      = LINE_EMPTY;
            elapsed   = '0;
            armed     = 1'b0;
            quiet_end = '0;
        endfunction

        function void apply_setting(cfg_index_t idx, logic [DATA_W-1:0] value);
            case (idx)
                CFG_EXPECTED:  want_acks = value[ACK_W-1:0];
                CFG_DEADLINE:  deadline  = value[DL_W-1:0];
                CFG_QUIET:     quiet_len = value[QT_W-1:0];
                CFG_MAX_BYTES: byte_cap  = value[CAP_W-1:0];
                default: ;
            endcase
        endfunction

        function result_t conclude(logic done, outcome_t o, reason_t r);
            result_t res;
            res.done    = done;
            res.outcome = o;
            res.reason  = r;
            res.acks    = acks;
            if (done)
                busy = 1'b0;
            return res;
        endfunction

        function result_t predict_outcome(logic [1:0] k, logic [7:0] b);
            if (k == KIND_START)
            begin
                clear_session();
                if (want_acks == 0)
                    return conclude(1'b1, OUT_FAILURE, RSN_EMPTY);
                if (want_acks > MAX_COMMANDS || deadline == 0 || byte_cap == 0)
                    return conclude(1'b1, OUT_FAILURE, RSN_BOUNDS);
                busy = 1'b1;
                return conclude(1'b0, OUT_PENDING, RSN_NONE);
            end
            if (!busy || k == KIND_IGNORED)
                return conclude(1'b0, OUT_PENDING, RSN_NONE);

            if (k == KIND_BYTE)
            begin
                if (rx_count >= byte_cap)
                    return conclude(1'b1, OUT_UNRESOLVED, RSN_BYTE_CAP);
                rx_count++;
                if (b != CHAR_CR && b != CHAR_LF)
                begin
                    line = (line == LINE_EMPTY && b == CHAR_PLUS) ? LINE_PLUS : LINE_OTHER;
                    return conclude(1'b0, OUT_PENDING, RSN_NONE);
                end
                if (line != LINE_PLUS)
                    return conclude(1'b1, OUT_UNRESOLVED, RSN_BAD_LINE);
                line = LINE_EMPTY;
                acks++;
                if (acks > want_acks)
                    return conclude(1'b1, OUT_UNRESOLVED, RSN_EXTRA_ACK);
                if (acks == want_acks)
                begin
                    quiet_end = QEND_W'(elapsed) + QEND_W'(quiet_len);
                    if (quiet_end > QEND_W'(deadline))
                        return conclude(1'b1, OUT_UNRESOLVED, RSN_QUIET_LATE);
                    armed = 1'b1;
                end
                return conclude(1'b0, OUT_PENDING, RSN_NONE);
            end

            // A tick: the deadline is checked before the quiet window.
            if (elapsed != TICK_MAX)
                elapsed++;
            if (elapsed >= deadline)
            begin
                if (line != LINE_EMPTY)
                    return conclude(1'b1, OUT_UNRESOLVED, RSN_PARTIAL);
                if (acks != want_acks)
                    return conclude(1'b1, OUT_UNRESOLVED, RSN_ACK_TMO);
                return conclude(1'b1, OUT_UNRESOLVED, RSN_QUIET_TMO);
            end
            if (armed && acks == want_acks && QEND_W'(elapsed) >= quiet_end)
                return conclude(1'b1, OUT_SUCCESS, RSN_NONE);
            return conclude(1'b0, OUT_PENDING, RSN_NONE);
        endfunction

        function void note_request(logic [1:0] k, logic [7:0] b);
            result_t predicted;
            requests++;
            if (k == KIND_START || (busy && k != KIND_IGNORED))
                counted++;
            predicted = predict_outcome(k, b);
            awaited.insert(awaited.size(), predicted);
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(logic d, logic [1:0] o, logic [3:0] r, logic [6:0] a);
            result_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing awaited: %0d %0d %0d %0d",
                         $time, d, o, r, a);
                return;
            end
            want = awaited.pop_front();
            checked++;
            compare_field("done_res", 8'(want.done), 8'(d));
            compare_field("outcome", 8'(want.outcome), 8'(o));
            compare_field("reason", 8'(want.reason), 8'(r));
            compare_field("acks_seen", 8'(want.acks), 8'(a));
            if (want.done)
                outcomes[want.outcome]++;
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        kind = KIND_TICK;
    logic [7:0]        rx_byte = 8'h00;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              done_res;
    logic [1:0]        outcome;
    logic [3:0]        reason;
    logic [6:0]        acks_seen;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = CFG_EXPECTED;
    logic [DATA_W-1:0] cfg_data = '0;

    ack_outcome_board board = new();

    // Sender burst bookkeeping, receiver stall pattern and hang detection.
    int burst_left = 0;
    int settings_done = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int stall_phase = 0;
    int idle_cycles = 0;

    command_ack_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .done_res  (done_res),
        .outcome   (outcome),
        .reason    (reason),
        .acks_seen (acks_seen),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver picks a new stall pattern after each random-length run:
    // never stalling, light random stalls, heavy random stalls, and a fixed
    // rhythm, so that stalls land on every phase of the pipeline.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(30, 200);
        end
        else
        begin
            stall_left--;
        end
        stall_phase++;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 9) < 6);
            default: out_stall <= ((stall_phase % 7) < 3);
        endcase
    end

    // All handshakes are observed here, at the rising edge, with the values
    // that were settled since the last falling edge. Requests are handed to
    // the scoreboard before results so the scoreboard sees them in order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.note_request(kind, rx_byte);
            if (out_valid && !out_stall)
                board.check_result(done_res, outcome, reason, acks_seen);
            if (cfg_valid && cfg_ready)
                board.apply_setting(cfg_index_t'(cfg_index), cfg_data);

            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= HANG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles, %0d results still awaited",
                         $time, HANG_LIMIT, board.awaited.size());
                $display("command_ack_tracker_test NOT OK");
                $finish;
            end
        end
    end

    // Offers one request and returns at the falling edge after it was taken.
    // The valid line is left high so that a following request goes out in the
    // very next cycle; a gap lowers it, and drain_results lowers it at the end
    // of a stretch of stimulus.
    task automatic send_request(logic [1:0] k, logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        kind     <= k;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        @(negedge clk);
    endtask

    // Stops sending and waits until every awaited result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (board.awaited.size() != 0)
            @(negedge clk);
    endtask

    // Writes all four registers back to back once the tracker has gone quiet.
    task automatic settle_and_set(int unsigned want, int unsigned dl, int unsigned q,
                                  int unsigned cap);
        cfg_index_t        order[4];
        logic [DATA_W-1:0] value[4];
        order[0] = CFG_EXPECTED;
        order[1] = CFG_DEADLINE;
        order[2] = CFG_QUIET;
        order[3] = CFG_MAX_BYTES;
        value[0] = DATA_W'(want);
        value[1] = DATA_W'(dl);
        value[2] = DATA_W'(q);
        value[3] = DATA_W'(cap);
        drain_results();
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= order[i];
            cfg_data  <= value[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    // One exchange: a start, then mostly a clean run of "+" lines with ticks
    // mixed in, sometimes an extra ack or a dangling byte, and otherwise a
    // burst of random requests biased toward plus signs and line ends. Ticks
    // then run the clock out, and line ends close whatever is still open.
    task automatic run_exchange();
        int unsigned need;
        int unsigned ticks;
        logic [1:0]  k;
        logic [7:0]  b;
        need = (board.want_acks == 0 || board.want_acks > MAX_COMMANDS) ? 1 : board.want_acks;
        send_request(KIND_START, 8'($urandom));
        if ($urandom_range(0, 9) < 7)
        begin
            for (int i = 0; i < need; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) send_request(KIND_TICK, 8'($urandom));
                if ($urandom_range(0, 19) == 0)
                    send_request(KIND_IGNORED, 8'($urandom));
                send_request(KIND_BYTE, CHAR_PLUS);
                send_request(KIND_BYTE, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
            end
            case ($urandom_range(0, 9))
                0:
                begin
                    send_request(KIND_BYTE, CHAR_PLUS);
                    send_request(KIND_BYTE, CHAR_LF);
                end
                1: send_request(KIND_BYTE, 8'($urandom));
                default: ;
            endcase
        end
        else
        begin
            repeat ($urandom_range(1, 24))
            begin
                case ($urandom_range(0, 15))
                    0: k = KIND_START;
                    1: k = KIND_IGNORED;
                    2, 3, 4, 5: k = KIND_TICK;
                    default: k = KIND_BYTE;
                endcase
                case ($urandom_range(0, 3))
                    0: b = CHAR_PLUS;
                    1: b = CHAR_CR;
                    2: b = CHAR_LF;
                    default: b = 8'($urandom);
                endcase
                send_request(k, b);
            end
        end
        ticks = 0;
        while (board.busy && ticks < TICK_BUDGET)
        begin
            send_request(KIND_TICK, 8'($urandom));
            ticks++;
        end
        while (board.busy)
            send_request(KIND_BYTE, CHAR_CR);
    endtask

    task automatic run_phase(int unsigned want, int unsigned dl, int unsigned q,
                             int unsigned cap, int exchanges);
        settle_and_set(want, dl, q, cap);
        repeat (exchanges) run_exchange();
    endtask

    initial
    begin
        int unsigned want;
        int unsigned dl;
        int unsigned cap;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Requests while idle are ignored, a second start drops the running
        // exchange, success comes one tick after the last ack when the quiet
        // window is zero even with a line half received, and both an extra ack
        // and an empty line end the exchange.
        settle_and_set(1, 3, 0, 4);
        send_request(KIND_TICK, 8'h00);
        send_request(KIND_BYTE, 8'hFF);
        send_request(KIND_IGNORED, 8'h00);
        send_request(KIND_START, 8'h00);
        send_request(KIND_BYTE, 8'h00);
        send_request(KIND_START, 8'hFF);
        send_request(KIND_BYTE, CHAR_PLUS);
        send_request(KIND_BYTE, CHAR_LF);
        send_request(KIND_BYTE, 8'hFF);
        send_request(KIND_TICK, 8'hFF);
        send_request(KIND_START, 8'h00);
        send_request(KIND_BYTE, CHAR_PLUS);
        send_request(KIND_BYTE, CHAR_CR);
        send_request(KIND_BYTE, CHAR_PLUS);
        send_request(KIND_BYTE, CHAR_CR);
        send_request(KIND_START, 8'h00);
        send_request(KIND_BYTE, CHAR_CR);

        // A one-tick deadline: it expires on a partial line, with the ack
        // missing, and with the quiet window still running.
        settle_and_set(1, 1, 1, 2);
        send_request(KIND_START, 8'h00);
        send_request(KIND_BYTE, CHAR_PLUS);
        send_request(KIND_TICK, 8'h00);
        send_request(KIND_START, 8'h00);
        send_request(KIND_TICK, 8'h00);
        send_request(KIND_START, 8'h00);
        send_request(KIND_BYTE, CHAR_PLUS);
        send_request(KIND_BYTE, CHAR_CR);
        send_request(KIND_TICK, 8'h00);

        // Start checks: nothing expected, and every bound out of range.
        settle_and_set(0, 65535, 65535, 8191);
        send_request(KIND_START, 8'h00);
        settle_and_set(127, 0, 0, 0);
        send_request(KIND_START, 8'h00);

        // Corner settings: the largest batch, the widest deadline and quiet window,
        // zero bounds one at a time, too large and empty batches, a one-byte cap.
        run_phase(64, 65535, 0, 8191, 3);
        run_phase(1, 65535, 65535, 8191, 2);
        run_phase(3, 0, 5, 100, 2);
        run_phase(3, 50, 5, 0, 2);
        run_phase(65, 50, 5, 100, 2);
        run_phase(0, 50, 5, 100, 2);
        run_phase(2, 1, 0, 1, 4);

        // Random settings: mostly small batches with tight deadlines so that
        // every kind of ending shows up, and now and then a long batch.
        while (board.counted < REQUEST_GOAL)
        begin
            want = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
            dl   = $urandom_range(1, 80);
            cap  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2 * want + 2)
                                                : $urandom_range(2 * want + 2, 300);
            run_phase(want, dl, $urandom_range(0, 15), cap, $urandom_range(4, 10));
        end

        drain_results();
        repeat (8) @(negedge clk);

        $display("Sent %0d requests (%0d acted on) under %0d settings; %0d results checked.",
                 board.requests, board.counted, settings_done, board.checked);
        $display("Exchanges ended: %0d success, %0d unresolved, %0d failure.",
                 board.outcomes[OUT_SUCCESS], board.outcomes[OUT_UNRESOLVED],
                 board.outcomes[OUT_FAILURE]);
        if (board.errors == 0 && board.awaited.size() == 0)
            $display("command_ack_tracker_test OK");
        else
            $display("command_ack_tracker_test NOT OK");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/cmdack_pkg.sv
design/cmdack_cfg.sv
design/cmdack_core.sv
design/command_ack_tracker.sv
verif/command_ack_tracker_test.sv
